// ===== rtl/i2cms_pkg.sv =====
package i2cms_pkg;

   localparam int unsigned DelayWidth = 16;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned ReqDataWidth = 16;
   localparam int unsigned RspDataWidth = 16;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] CSR_DELAY_LONG   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_DELAY_SETUP  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_DELAY_HOLD   = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_DELAY_SAMPLE = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_POLL_LIMIT   = 3'd4;

   localparam logic [DelayWidth-1:0] DELAY_LONG_RESET   = 16'd40;
   localparam logic [DelayWidth-1:0] DELAY_SETUP_RESET  = 16'd20;
   localparam logic [DelayWidth-1:0] DELAY_HOLD_RESET   = 16'd10;
   localparam logic [DelayWidth-1:0] DELAY_SAMPLE_RESET = 16'd5;
   localparam logic [ByteWidth-1:0]  POLL_LIMIT_RESET   = 8'd250;

   localparam logic [ByteWidth-1:0] MSB_MASK = 8'h80;
   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_START  = 3'd1,
      CMD_STOP   = 3'd2,
      CMD_WRITE  = 3'd3,
      CMD_READ   = 3'd4,
      CMD_WAIT_ACK = 3'd5
   } cmd_type;

   typedef enum logic [4:0] {
      PH_IDLE = 5'd0,
      PH_S1   = 5'd1,
      PH_S2   = 5'd2,
      PH_S3   = 5'd3,
      PH_P1   = 5'd4,
      PH_P2   = 5'd5,
      PH_W1   = 5'd6,
      PH_W2   = 5'd7,
      PH_W3   = 5'd8,
      PH_R0   = 5'd9,
      PH_R1   = 5'd10,
      PH_R2   = 5'd11,
      PH_R3   = 5'd12,
      PH_A1   = 5'd13,
      PH_A2   = 5'd14,
      PH_K0   = 5'd15,
      PH_K1   = 5'd16,
      PH_K2   = 5'd17
   } phase_type;

   typedef struct packed {
      logic [DelayWidth-1:0] delay_long;
      logic [DelayWidth-1:0] delay_setup;
      logic [DelayWidth-1:0] delay_hold;
      logic [DelayWidth-1:0] delay_sample;
      logic [ByteWidth-1:0]  poll_limit;
   } cfg_type;

   typedef struct packed {
      phase_type             phase;
      logic [2:0]            command;
      logic [3:0]            bit_index;
      logic [DelayWidth-1:0] delay_left;
      logic [ByteWidth-1:0]  shift_data;
      logic [ByteWidth-1:0]  poll_count;
      logic                  scl;
      logic                  sda;
      logic                  sda_dir;
      logic                  ack_flag;
      logic                  ack_choice;
      logic [ByteWidth-1:0]  rx_byte;
   } state_type;

   typedef struct packed {
      logic [2:0]           req_type;
      logic [ByteWidth-1:0] tx_byte;
      logic                 send_ack;
      logic                 sda_in;
      logic                 us_tick;
   } req_type_t_type;

   typedef struct packed {
      logic                 scl_level;
      logic                 sda_level;
      logic                 sda_drive;
      logic                 busy_res;
      logic                 done_res;
      logic [ByteWidth-1:0] rx_byte;
      logic                 ack_seen;
   } rsp_type;

endpackage

// ===== rtl/i2cms_step.sv =====
module i2cms_step (
   input  i2cms_pkg::state_type       state_cur,
   input  i2cms_pkg::cfg_type         cfg,
   input  i2cms_pkg::req_type_t_type  req,
   output i2cms_pkg::state_type       state_nxt,
   output i2cms_pkg::rsp_type         rsp
);

   logic [i2cms_pkg::DelayWidth-1:0] long_d;
   logic [i2cms_pkg::DelayWidth-1:0] setup_d;
   logic [i2cms_pkg::DelayWidth-1:0] hold_d;
   logic [i2cms_pkg::DelayWidth-1:0] sample_d;
   logic                             expired;
   logic [i2cms_pkg::DelayWidth-1:0] left_dec;
   logic [3:0]                       bit_inc;
   logic [i2cms_pkg::ByteWidth-1:0]  poll_inc;
   logic                             done;

   // A delay register written with zero behaves as one.
   assign long_d   = (cfg.delay_long   == '0) ? 16'd1 : cfg.delay_long;
   assign setup_d  = (cfg.delay_setup  == '0) ? 16'd1 : cfg.delay_setup;
   assign hold_d   = (cfg.delay_hold   == '0) ? 16'd1 : cfg.delay_hold;
   assign sample_d = (cfg.delay_sample == '0) ? 16'd1 : cfg.delay_sample;

   // A timed phase ends on the tick that takes the count to zero.
   assign expired  = req.us_tick && (state_cur.delay_left <= 16'd1);
   assign left_dec = !req.us_tick ? state_cur.delay_left :
                     (expired ? '0 : state_cur.delay_left - 16'd1);
   assign bit_inc  = state_cur.bit_index + 4'd1;
   assign poll_inc = state_cur.poll_count + 8'd1;

   always_comb begin
      state_nxt = state_cur;
      done = 1'b0;
      unique case (state_cur.phase)
         i2cms_pkg::PH_IDLE: begin
            case (req.req_type)
               i2cms_pkg::CMD_START: begin
                  state_nxt.command = req.req_type;
                  state_nxt.sda_dir = 1'b1;
                  state_nxt.sda = 1'b1;
                  state_nxt.delay_left = long_d;
                  state_nxt.phase = i2cms_pkg::PH_S1;
               end
               i2cms_pkg::CMD_STOP: begin
                  state_nxt.command = req.req_type;
                  state_nxt.sda_dir = 1'b1;
                  state_nxt.scl = 1'b0;
                  state_nxt.sda = 1'b0;
                  state_nxt.delay_left = long_d;
                  state_nxt.phase = i2cms_pkg::PH_P1;
               end
               i2cms_pkg::CMD_WRITE: begin
                  state_nxt.command = req.req_type;
                  state_nxt.sda_dir = 1'b1;
                  state_nxt.scl = 1'b0;
                  state_nxt.bit_index = '0;
                  state_nxt.sda = req.tx_byte[7];
                  state_nxt.shift_data = {req.tx_byte[6:0], 1'b0};
                  state_nxt.delay_left = setup_d;
                  state_nxt.phase = i2cms_pkg::PH_W1;
               end
               i2cms_pkg::CMD_READ: begin
                  state_nxt.command = req.req_type;
                  state_nxt.sda_dir = 1'b0;
                  state_nxt.scl = 1'b0;
                  state_nxt.sda = 1'b1;
                  state_nxt.shift_data = '0;
                  state_nxt.bit_index = '0;
                  state_nxt.ack_choice = req.send_ack;
                  state_nxt.delay_left = setup_d;
                  state_nxt.phase = i2cms_pkg::PH_R0;
               end
               i2cms_pkg::CMD_WAIT_ACK: begin
                  state_nxt.command = req.req_type;
                  state_nxt.sda_dir = 1'b0;
                  state_nxt.scl = 1'b0;
                  state_nxt.sda = 1'b1;
                  state_nxt.delay_left = setup_d;
                  state_nxt.phase = i2cms_pkg::PH_K0;
               end
               default: begin
               end
            endcase
         end
         i2cms_pkg::PH_S1: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.scl = 1'b1;
               state_nxt.delay_left = long_d;
               state_nxt.phase = i2cms_pkg::PH_S2;
            end
         end
         i2cms_pkg::PH_S2: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.sda = 1'b0;
               state_nxt.delay_left = long_d;
               state_nxt.phase = i2cms_pkg::PH_S3;
            end
         end
         i2cms_pkg::PH_S3: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.scl = 1'b0;
               done = 1'b1;
            end
         end
         i2cms_pkg::PH_P1: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.scl = 1'b1;
               state_nxt.sda = 1'b1;
               state_nxt.delay_left = long_d;
               state_nxt.phase = i2cms_pkg::PH_P2;
            end
         end
         i2cms_pkg::PH_P2: begin
            state_nxt.delay_left = left_dec;
            done = expired;
         end
         i2cms_pkg::PH_W1: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.scl = 1'b1;
               state_nxt.delay_left = hold_d;
               state_nxt.phase = i2cms_pkg::PH_W2;
            end
         end
         i2cms_pkg::PH_W2: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.scl = 1'b0;
               state_nxt.delay_left = hold_d;
               state_nxt.phase = i2cms_pkg::PH_W3;
            end
         end
         i2cms_pkg::PH_W3: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.bit_index = bit_inc;
               if (bit_inc >= i2cms_pkg::BITS_PER_BYTE) begin
                  done = 1'b1;
               end else begin
                  state_nxt.sda = state_cur.shift_data[7];
                  state_nxt.shift_data = {state_cur.shift_data[6:0], 1'b0};
                  state_nxt.delay_left = setup_d;
                  state_nxt.phase = i2cms_pkg::PH_W1;
               end
            end
         end
         i2cms_pkg::PH_R0: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.scl = 1'b1;
               state_nxt.delay_left = sample_d;
               state_nxt.phase = i2cms_pkg::PH_R1;
            end
         end
         i2cms_pkg::PH_R1: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               if (req.sda_in) begin
                  state_nxt.shift_data = state_cur.shift_data |
                     (i2cms_pkg::MSB_MASK >> state_cur.bit_index[2:0]);
               end
               state_nxt.delay_left = sample_d;
               state_nxt.phase = i2cms_pkg::PH_R2;
            end
         end
         i2cms_pkg::PH_R2: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.scl = 1'b0;
               state_nxt.delay_left = sample_d;
               state_nxt.phase = i2cms_pkg::PH_R3;
            end
         end
         i2cms_pkg::PH_R3: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.bit_index = bit_inc;
               if (bit_inc >= i2cms_pkg::BITS_PER_BYTE) begin
                  state_nxt.rx_byte = state_cur.shift_data;
                  state_nxt.sda_dir = 1'b1;
                  state_nxt.scl = 1'b0;
                  state_nxt.sda = !state_cur.ack_choice;
                  state_nxt.delay_left = long_d;
                  state_nxt.phase = i2cms_pkg::PH_A1;
               end else begin
                  state_nxt.scl = 1'b1;
                  state_nxt.delay_left = sample_d;
                  state_nxt.phase = i2cms_pkg::PH_R1;
               end
            end
         end
         i2cms_pkg::PH_A1: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.scl = 1'b1;
               state_nxt.delay_left = long_d;
               state_nxt.phase = i2cms_pkg::PH_A2;
            end
         end
         i2cms_pkg::PH_A2: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.scl = 1'b0;
               done = 1'b1;
            end
         end
         i2cms_pkg::PH_K0: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.poll_count = '0;
               state_nxt.phase = i2cms_pkg::PH_K1;
            end
         end
         i2cms_pkg::PH_K1: begin
            // Polling runs on every item, with or without a tick.
            if (!req.sda_in) begin
               state_nxt.sda_dir = 1'b1;
               state_nxt.sda = 1'b0;
               state_nxt.delay_left = long_d;
               state_nxt.phase = i2cms_pkg::PH_K2;
            end else begin
               state_nxt.poll_count = poll_inc;
               if (poll_inc >= cfg.poll_limit) begin
                  state_nxt.ack_flag = 1'b0;
                  done = 1'b1;
               end
            end
         end
         i2cms_pkg::PH_K2: begin
            state_nxt.delay_left = left_dec;
            if (expired) begin
               state_nxt.scl = 1'b1;
               state_nxt.ack_flag = 1'b1;
               done = 1'b1;
            end
         end
         default: begin
            state_nxt.phase = i2cms_pkg::PH_IDLE;
         end
      endcase
      if (done) begin
         state_nxt.phase = i2cms_pkg::PH_IDLE;
         state_nxt.delay_left = '0;
      end
   end

   always_comb begin
      rsp.scl_level = state_nxt.scl;
      rsp.sda_level = state_nxt.sda;
      rsp.sda_drive = state_nxt.sda_dir;
      rsp.busy_res  = (state_nxt.phase != i2cms_pkg::PH_IDLE);
      rsp.done_res  = done;
      rsp.rx_byte   = state_nxt.rx_byte;
      rsp.ack_seen  = state_nxt.ack_flag;
   end

endmodule

// ===== rtl/i2c_master_bit_sequencer_core.sv =====
// Channel  Ports                Payload
// req      req_tvalid/tready    tdata: req_type, tx_byte, send_ack, sda_in, us_tick
// rsp      rsp_tvalid/tready    tdata: pin levels, busy, rx_byte, ack_seen; tlast: done
// csr      csr_we/index/wdata   one register per write (16 bits, poll limit [7:0]), no read-back
//
// Every item yields one result item; one item is taken per clock when the result
// side keeps up. An item is captured in the input register when it is accepted and
// is stepped through the sequencer into the result register when the result side
// can advance. Reset returns the bus to idle (SCL and SDA high, SDA driven) and loads
// the default delays. When a result is held and rsp_tready is low the result
// register holds, the input register fills, and then req_tready drops.
module i2c_master_bit_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] req_type, [10:3] tx_byte, [11] send_ack, [12] sda_in, [13] us_tick
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [11:4] rx_byte,
   // [12] ack_seen
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   i2cms_pkg::cfg_type         cfg_ff;
   i2cms_pkg::state_type       state_ff;
   i2cms_pkg::state_type       state_in;
   i2cms_pkg::req_type_t_type  req_ff;
   i2cms_pkg::rsp_type         rsp_in;
   i2cms_pkg::rsp_type         rsp_ff;
   logic                       req_valid_ff;
   logic                       rsp_valid_ff;
   logic                       advance;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_long   <= i2cms_pkg::DELAY_LONG_RESET;
         cfg_ff.delay_setup  <= i2cms_pkg::DELAY_SETUP_RESET;
         cfg_ff.delay_hold   <= i2cms_pkg::DELAY_HOLD_RESET;
         cfg_ff.delay_sample <= i2cms_pkg::DELAY_SAMPLE_RESET;
         cfg_ff.poll_limit   <= i2cms_pkg::POLL_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            i2cms_pkg::CSR_DELAY_LONG:   cfg_ff.delay_long   <= csr_wdata;
            i2cms_pkg::CSR_DELAY_SETUP:  cfg_ff.delay_setup  <= csr_wdata;
            i2cms_pkg::CSR_DELAY_HOLD:   cfg_ff.delay_hold   <= csr_wdata;
            i2cms_pkg::CSR_DELAY_SAMPLE: cfg_ff.delay_sample <= csr_wdata;
            i2cms_pkg::CSR_POLL_LIMIT:   cfg_ff.poll_limit   <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
      if (req_tready) begin
         req_ff.req_type <= req_tdata[2:0];
         req_ff.tx_byte  <= req_tdata[10:3];
         req_ff.send_ack <= req_tdata[11];
         req_ff.sda_in   <= req_tdata[12];
         req_ff.us_tick  <= req_tdata[13];
      end
   end

   i2cms_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .req       (req_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= i2cms_pkg::PH_IDLE;
         state_ff.command    <= '0;
         state_ff.bit_index  <= '0;
         state_ff.delay_left <= '0;
         state_ff.shift_data <= '0;
         state_ff.poll_count <= '0;
         state_ff.scl        <= 1'b1;
         state_ff.sda        <= 1'b1;
         state_ff.sda_dir    <= 1'b1;
         state_ff.ack_flag   <= 1'b0;
         state_ff.ack_choice <= 1'b0;
         state_ff.rx_byte    <= '0;
         rsp_valid_ff        <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
         if (req_valid_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.done_res;
   assign rsp_tdata  = {3'b000, rsp_ff.ack_seen, rsp_ff.rx_byte, rsp_ff.busy_res,
                        rsp_ff.sda_drive, rsp_ff.sda_level, rsp_ff.scl_level};

   // A finished command always leaves the sequencer idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> !rsp_ff.busy_res)
      else $error("done reported while still busy");

   // The delay counter is cleared whenever the sequencer is idle.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == i2cms_pkg::PH_IDLE |-> state_ff.delay_left == '0)
      else $error("delay count left over in idle");

   // The bit counter never runs past one byte.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.bit_index <= i2cms_pkg::BITS_PER_BYTE)
      else $error("bit index beyond a byte");

   // An item in the input register moves to the result register when it advances.
   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && advance |=> rsp_valid_ff)
      else $error("item lost between input and result registers");

endmodule
